// ===== sv/ucl_pkg.sv =====
// ----------------------------------------------------------------------------
// ucl_pkg
// Shared types and codes for the Unix time to local civil time pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ucl_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZONE_BAD = 2'd1;
  localparam logic [1:0] ST_NEGATIVE = 2'd2;

  // fields that ride along unchanged from stage 1 to the output
  typedef struct packed {
    logic [1:0] status;
    logic       offset_negative;
    logic [3:0] offset_hours;
    logic [5:0] offset_mins;
    logic       utc_marker;
  } side_t;

  // handoff from the day split to the date and clock paths
  typedef struct packed {
    logic [16:0] sod;
    logic [17:0] doe;
    logic        era5;
    side_t       side;
  } front_t;

endpackage

`default_nettype wire

// ===== sv/ucl_front.sv =====
// ----------------------------------------------------------------------------
// ucl_front
// Stages 1-3: zone offset and local seconds, day count, second of day and
// day of era.
// ----------------------------------------------------------------------------
`default_nettype none

module ucl_front (
  input  logic            clk,
  input  logic [2:0]      en,
  input  logic [31:0]     unix_seconds,
  input  logic [6:0]      zone_quarter_hours,
  input  logic            utc_form,
  output ucl_pkg::front_t front
);
  import ucl_pkg::*;

  localparam logic signed [6:0] ZONE_MIN  = -7'sd48;
  localparam logic signed [6:0] ZONE_MAX  = 7'sd56;
  localparam logic [26:0]       DAY_RECIP = 27'd101806633;  // 2^36 / 675, rounded up
  localparam logic [32:0]       SECS_DAY  = 33'd86400;
  localparam logic [19:0]       DAY_SHIFT = 20'd719468;
  localparam logic [19:0]       ERA4      = 20'd584388;
  localparam logic [19:0]       ERA5      = 20'd730485;

  // stage 1
  logic [17:0]        zone_ext;
  logic [17:0]        zone_secs;
  logic signed [33:0] local_s;
  logic               zone_bad;
  logic [6:0]         abs_q;
  side_t              side1_next;
  logic [32:0]        local1_next;
  side_t              side1;
  logic [32:0]        local1;

  // stage 2
  logic [52:0] day_prod;
  logic [15:0] days2;
  logic [16:0] lo2;
  side_t       side2;

  // stage 3
  logic [32:0] day_secs;
  logic [19:0] z3;
  logic        era5_next;

  always_comb begin
    zone_ext  = {{11{zone_quarter_hours[6]}}, zone_quarter_hours};
    zone_secs = 18'($signed(zone_ext) * $signed(18'sd900));
    local_s   = $signed({2'b00, unix_seconds}) + $signed({{16{zone_secs[17]}}, zone_secs});
    zone_bad  = ($signed(zone_quarter_hours) < ZONE_MIN) ||
                ($signed(zone_quarter_hours) > ZONE_MAX);
    abs_q     = zone_quarter_hours[6] ? 7'(-zone_quarter_hours) : zone_quarter_hours;

    side1_next = '0;
    side1_next.utc_marker = utc_form;
    if (utc_form) begin
      local1_next = {1'b0, unix_seconds};
    end else begin
      local1_next = local_s[32:0];
      side1_next.offset_negative = zone_quarter_hours[6];
      side1_next.offset_hours    = abs_q[5:2];
      side1_next.offset_mins     = 6'(abs_q[1:0]) * 6'd15;
      if (zone_bad) begin
        side1_next.status = ST_ZONE_BAD;
      end else if (local_s[33]) begin
        side1_next.status = ST_NEGATIVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side1  <= side1_next;
      local1 <= local1_next;
    end
  end

  // t / 86400 == (t >> 7) / 675
  assign day_prod = 53'(local1[32:7]) * 53'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      days2 <= day_prod[51:36];
      lo2   <= local1[16:0];
      side2 <= side1;
    end
  end

  always_comb begin
    day_secs  = 33'(days2) * SECS_DAY;
    z3        = 20'(days2) + DAY_SHIFT;
    era5_next = (z3 >= ERA5);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      front.sod  <= lo2 - day_secs[16:0];
      front.doe  <= 18'(z3 - (era5_next ? ERA5 : ERA4));
      front.era5 <= era5_next;
      front.side <= side2;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucl_date.sv =====
// ----------------------------------------------------------------------------
// ucl_date
// Stages 4-9: day of era to year, month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module ucl_date (
  input  logic            clk,
  input  logic [5:0]      en,
  input  ucl_pkg::front_t front,
  output logic [11:0]     year,
  output logic [3:0]      month,
  output logic [4:0]      day_of_month
);
  import ucl_pkg::*;

  localparam logic [36:0] RECIP_1460  = 37'd367720;  // 2^29 / 1460
  localparam logic [36:0] RECIP_36524 = 37'd470373;  // 2^34 / 36524
  localparam logic [36:0] RECIP_365   = 37'd367720;  // 2^27 / 365
  localparam logic [22:0] RECIP_153   = 23'd3427;    // 2^19 / 153
  localparam logic [17:0] LAST_DOE    = 18'd146096;

  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // stage 4
  logic [36:0] pa;
  logic [36:0] pb;
  logic [7:0]  a4;
  logic [2:0]  b4;
  logic        c4;
  logic [17:0] doe4;
  logic        era4;

  // stage 5
  logic [17:0] n5;
  logic [17:0] doe5;
  logic        era5;

  // stage 6
  logic [36:0] pn;
  logic [8:0]  yoe6;
  logic [17:0] doe6;
  logic        era6;

  // stage 7
  logic [1:0]  cent;
  logic [17:0] yday;
  logic [8:0]  doy7;
  logic [8:0]  yoe7;
  logic        era7;

  // stage 8
  logic [10:0] mnum;
  logic [22:0] pm;
  logic [3:0]  mp8;
  logic [8:0]  doy8;
  logic [8:0]  yoe8;
  logic        era8;

  // stage 9
  logic [3:0]  month_next;
  logic [11:0] base_year;

  assign pa = 37'(front.doe) * RECIP_1460;
  assign pb = 37'(front.doe) * RECIP_36524;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a4   <= pa[36:29];
      b4   <= pb[36:34];
      c4   <= (front.doe == LAST_DOE);
      doe4 <= front.doe;
      era4 <= front.era5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n5   <= doe4 - 18'(a4) + 18'(b4) - 18'(c4);
      doe5 <= doe4;
      era5 <= era4;
    end
  end

  assign pn = 37'(n5) * RECIP_365;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      yoe6 <= pn[35:27];
      doe6 <= doe5;
      era6 <= era5;
    end
  end

  always_comb begin
    cent = 2'(yoe6 >= 9'd100) + 2'(yoe6 >= 9'd200) + 2'(yoe6 >= 9'd300);
    yday = 18'(yoe6) * 18'd365 + 18'(yoe6[8:2]) - 18'(cent);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      doy7 <= 9'(doe6 - yday);
      yoe7 <= yoe6;
      era7 <= era6;
    end
  end

  assign mnum = 11'(doy7) * 11'd5 + 11'd2;
  assign pm   = 23'(mnum) * RECIP_153;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mp8  <= pm[22:19];
      doy8 <= doy7;
      yoe8 <= yoe7;
      era8 <= era7;
    end
  end

  // years run March to February; January and February belong to the next one
  always_comb begin
    month_next = (mp8 < 4'd10) ? mp8 + 4'd3 : mp8 - 4'd9;
    base_year  = era8 ? 12'd2000 : 12'd1600;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      day_of_month <= 5'(doy8 - month_start(mp8) + 9'd1);
      month        <= month_next;
      year         <= 12'(yoe8) + base_year + 12'(mp8 >= 4'd10);
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucl_clock.sv =====
// ----------------------------------------------------------------------------
// ucl_clock
// Stages 4-9: second of day to hour, minute and second; carries the status
// and offset fields alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ucl_clock (
  input  logic            clk,
  input  logic [5:0]      en,
  input  ucl_pkg::front_t front,
  output logic [4:0]      hour,
  output logic [5:0]      minute,
  output logic [5:0]      second,
  output ucl_pkg::side_t  side
);
  import ucl_pkg::*;

  localparam logic [34:0] RECIP_3600 = 35'd149131;  // 2^29 / 3600
  localparam logic [24:0] RECIP_60   = 25'd4370;    // 2^18 / 60

  logic [34:0] ph;
  logic [4:0]  hour4;
  logic [16:0] sod4;
  logic [4:0]  hour5;
  logic [11:0] rem5;
  logic [24:0] pm;
  logic [4:0]  hour6;
  logic [5:0]  minute6;
  logic [11:0] rem6;
  logic [4:0]  hour7;
  logic [5:0]  minute7;
  logic [5:0]  second7;
  logic [4:0]  hour8;
  logic [5:0]  minute8;
  logic [5:0]  second8;
  side_t       side_q [6];

  assign ph = 35'(front.sod) * RECIP_3600;
  assign pm = 25'(rem5) * RECIP_60;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hour4 <= ph[33:29];
      sod4  <= front.sod;
    end
    if (en[1]) begin
      hour5 <= hour4;
      rem5  <= 12'(sod4 - 17'(hour4) * 17'd3600);
    end
    if (en[2]) begin
      hour6   <= hour5;
      minute6 <= pm[23:18];
      rem6    <= rem5;
    end
    if (en[3]) begin
      hour7   <= hour6;
      minute7 <= minute6;
      second7 <= 6'(rem6 - 12'(minute6) * 12'd60);
    end
    if (en[4]) begin
      hour8   <= hour7;
      minute8 <= minute7;
      second8 <= second7;
    end
    if (en[5]) begin
      hour   <= hour8;
      minute <= minute8;
      second <= second8;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_q[0] <= front.side;
    end
    for (int i = 1; i < 6; i++) begin
      if (en[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign side = side_q[5];

endmodule

`default_nettype wire

// ===== sv/unix_time_to_local_civil_time.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_local_civil_time
// Unix seconds plus a quarter-hour time zone to a Gregorian date and a time
// of day, with the zone offset split into sign, hours and minutes.
//
// s_axis carries one timestamp per word: seconds and zone in tdata, the UTC
// flag in tuser. m_axis returns one result word per input word, in order,
// with the UTC flag echoed in tuser.
// Nine register stages. One word per cycle sustained while m_axis does not
// stall: every multiply in a stage is by a constant, with a few adds and
// compares around it.
// A stall on m_axis holds the last stage; earlier stages keep filling empty
// slots, and s_axis_tready drops only once the pipeline is full, so no word
// is lost or repeated.
// rst clears the stage valid bits; the pipeline comes up empty and ready.
// Unless the UTC flag is set, a bad zone or a local time before 1970 returns
// a status code with all other fields zero.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_local_civil_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // unix_seconds[31:0], zone_quarter_hours[38:32]
  input  logic        s_axis_tuser,  // utc_form
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // status[1:0], year[13:2], month[17:14],
                                     // day_of_month[22:18], hour[27:23],
                                     // minute[33:28], second[39:34],
                                     // offset_negative[40], offset_hours[44:41],
                                     // offset_mins[50:45]
  output logic        m_axis_tuser   // utc_marker
);
  import ucl_pkg::*;

  localparam int Stages = 9;

  logic [Stages:1] valid;
  logic [Stages:1] en;
  front_t          front;
  logic [11:0]     year;
  logic [3:0]      month;
  logic [4:0]      day_of_month;
  logic [4:0]      hour;
  logic [5:0]      minute;
  logic [5:0]      second;
  side_t           side;
  logic            ok;

  always_comb begin
    en[Stages] = !valid[Stages] || m_axis_tready;
    for (int i = Stages - 1; i >= 1; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) begin
        valid[1] <= s_axis_tvalid;
      end
      for (int i = 2; i <= Stages; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  ucl_front u_front (
    .clk                (clk),
    .en                 (en[3:1]),
    .unix_seconds       (s_axis_tdata[31:0]),
    .zone_quarter_hours (s_axis_tdata[38:32]),
    .utc_form           (s_axis_tuser),
    .front              (front)
  );

  ucl_date u_date (
    .clk          (clk),
    .en           (en[9:4]),
    .front        (front),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month)
  );

  ucl_clock u_clock (
    .clk    (clk),
    .en     (en[9:4]),
    .front  (front),
    .hour   (hour),
    .minute (minute),
    .second (second),
    .side   (side)
  );

  assign ok            = (side.status == ST_OK);
  assign s_axis_tready = en[1];
  assign m_axis_tvalid = valid[Stages];
  assign m_axis_tuser  = ok & side.utc_marker;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[1:0] = side.status;
    if (ok) begin
      m_axis_tdata[13:2]  = year;
      m_axis_tdata[17:14] = month;
      m_axis_tdata[22:18] = day_of_month;
      m_axis_tdata[27:23] = hour;
      m_axis_tdata[33:28] = minute;
      m_axis_tdata[39:34] = second;
      m_axis_tdata[40]    = side.offset_negative;
      m_axis_tdata[44:41] = side.offset_hours;
      m_axis_tdata[50:45] = side.offset_mins;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucl_checker.sv =====
// ----------------------------------------------------------------------------
// ucl_checker
// Port-level checks for unix_time_to_local_civil_time.
// ----------------------------------------------------------------------------
`default_nettype none

module ucl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import ucl_pkg::*;

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // empty after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  // an error word carries nothing but its status
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |->
      (m_axis_tdata[55:2] == '0) && !m_axis_tuser)
    else $error("error word has nonzero fields");

  // good word has a sane date and clock
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == ST_OK) |->
      (m_axis_tdata[17:14] >= 4'd1) && (m_axis_tdata[17:14] <= 4'd12) &&
      (m_axis_tdata[22:18] >= 5'd1) && (m_axis_tdata[27:23] <= 5'd23) &&
      (m_axis_tdata[33:28] <= 6'd59) && (m_axis_tdata[39:34] <= 6'd59) &&
      (m_axis_tdata[13:2] >= 12'd1970) && (m_axis_tdata[13:2] <= 12'd2106))
    else $error("result field out of range");

  // a UTC word has no zone offset
  a_utc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[1:0] == ST_OK) && (m_axis_tdata[50:40] == '0))
    else $error("UTC word carries an offset");

endmodule

bind unix_time_to_local_civil_time ucl_checker u_ucl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb_unix_time_to_local_civil_time.sv =====
// ----------------------------------------------------------------------------
// tb_unix_time_to_local_civil_time
// Streams timestamps through the converter with random gaps on s_axis and
// random back-pressure on m_axis. Each accepted word is converted by a
// local calendar model and every result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_unix_time_to_local_civil_time;
  timeunit 1ns;
  timeprecision 1ps;

  import ucl_pkg::*;

  localparam int ZONE_WEST_LIMIT  = -48;
  localparam int ZONE_EAST_LIMIT  = 56;
  localparam int SECS_PER_QUARTER = 900;
  localparam int RANDOM_STAMPS    = 800;
  localparam int DRAIN_CYCLES     = 30;
  localparam int PRINT_LIMIT      = 100;

  typedef struct packed {
    logic [31:0]       secs;
    logic signed [6:0] zone;
    logic              utc;
  } stamp_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        off_neg;
    logic [3:0]  off_hours;
    logic [5:0]  off_minutes;
    logic        utc_marker;
  } civil_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  stamp_t   cur_stamp = '0;
  stamp_t   pending_stamps[$];
  civil_t   expected_civil[$];
  int       stamps_total = 0;
  int       stamps_sent = 0;
  int       words_seen = 0;
  int       err_count = 0;

  assign s_axis_tdata = {1'b0, cur_stamp.zone, cur_stamp.secs};
  assign s_axis_tuser = cur_stamp.utc;

  unix_time_to_local_civil_time dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // proleptic Gregorian breakdown of local seconds
  function automatic civil_t convert_stamp(stamp_t s);
    civil_t r;
    longint local_secs, days, sod, z, era, doe, yoe, yr, doy, mp, md, mo;
    int qh, absmin;
    r = '0;
    qh = int'(s.zone);
    local_secs = longint'(s.secs);
    if (s.utc) begin
      r.utc_marker = 1'b1;
    end else begin
      if (qh < ZONE_WEST_LIMIT || qh > ZONE_EAST_LIMIT) begin
        r.status = ST_ZONE_BAD;
        return r;
      end
      local_secs = local_secs + qh * SECS_PER_QUARTER;
      if (local_secs < 0) begin
        r.status = ST_NEGATIVE;
        return r;
      end
      absmin = (qh < 0) ? -qh * 15 : qh * 15;
      r.off_neg = (qh < 0);
      r.off_hours = 4'(absmin / 60);
      r.off_minutes = 6'(absmin % 60);
    end
    days = local_secs / 86400;
    sod  = local_secs % 86400;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr   = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    md   = doy - (153 * mp + 2) / 5 + 1;
    mo   = (mp < 10) ? mp + 3 : mp - 9;
    if (mo <= 2) yr = yr + 1;
    r.status = ST_OK;
    r.year   = 12'(yr);
    r.month  = 4'(mo);
    r.mday   = 5'(md);
    r.hour   = 5'(sod / 3600);
    r.minute = 6'((sod / 60) % 60);
    r.second = 6'(sod % 60);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_LIMIT) $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0d want %0d", words_seen, name, got, want));
  endtask

  task automatic add_stamp(logic [31:0] secs, int zone, bit utc);
    stamp_t s;
    s.secs = secs;
    s.zone = 7'(zone);
    s.utc  = utc;
    pending_stamps.push_back(s);
    stamps_total++;
  endtask

  // source side
  int src_gap = 0;
  int src_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_civil.push_back(convert_stamp(cur_stamp));
        stamps_sent++;
      end
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_stamps.size() != 0) begin
        cur_stamp <= pending_stamps.pop_front();
        s_axis_tvalid <= 1'b1;
        if (src_calm != 0) begin
          src_calm--;
        end else begin
          if ($urandom_range(0, 49) == 0) src_calm = 60;
          src_gap = pick_gap();
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  int sink_stall = 0;
  int sink_calm = 0;
  always @(posedge clk) begin : sink_proc
    civil_t got, want;
    int r;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_civil.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with no stamp outstanding", words_seen));
        end else begin
          want = expected_civil.pop_front();
          got.status      = m_axis_tdata[1:0];
          got.year        = m_axis_tdata[13:2];
          got.month       = m_axis_tdata[17:14];
          got.mday        = m_axis_tdata[22:18];
          got.hour        = m_axis_tdata[27:23];
          got.minute      = m_axis_tdata[33:28];
          got.second      = m_axis_tdata[39:34];
          got.off_neg     = m_axis_tdata[40];
          got.off_hours   = m_axis_tdata[44:41];
          got.off_minutes = m_axis_tdata[50:45];
          got.utc_marker  = m_axis_tuser;
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("year", 32'(got.year), 32'(want.year));
          check_field("month", 32'(got.month), 32'(want.month));
          check_field("day_of_month", 32'(got.mday), 32'(want.mday));
          check_field("hour", 32'(got.hour), 32'(want.hour));
          check_field("minute", 32'(got.minute), 32'(want.minute));
          check_field("second", 32'(got.second), 32'(want.second));
          check_field("offset_negative", 32'(got.off_neg), 32'(want.off_neg));
          check_field("offset_hours", 32'(got.off_hours), 32'(want.off_hours));
          check_field("offset_mins", 32'(got.off_minutes), 32'(want.off_minutes));
          check_field("utc_marker", 32'(got.utc_marker), 32'(want.utc_marker));
        end
        words_seen++;
      end
      if (sink_stall != 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (sink_calm != 0) begin
        sink_calm--;
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          sink_calm = 80;
          m_axis_tready <= 1'b1;
        end else if (r < 25) begin
          sink_stall = pick_gap();
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int r, zone;
    logic [31:0] secs;

    // epoch and range ends
    add_stamp(32'd0, 0, 1'b0);
    add_stamp(32'hFFFF_FFFF, 0, 1'b0);
    add_stamp(32'hFFFF_FFFF, ZONE_EAST_LIMIT, 1'b0);
    add_stamp(32'hFFFF_FFFF, 0, 1'b1);
    // local time before the epoch, and exactly at it
    add_stamp(32'd0, ZONE_WEST_LIMIT, 1'b0);
    add_stamp(32'd43200, ZONE_WEST_LIMIT, 1'b0);
    add_stamp(32'd43199, ZONE_WEST_LIMIT, 1'b0);
    add_stamp(32'd0, -1, 1'b0);
    // UTC form skips the zone check
    add_stamp(32'd0, -64, 1'b1);
    add_stamp(32'd1000, 63, 1'b1);
    // zone out of range
    add_stamp(32'd1000, ZONE_WEST_LIMIT - 1, 1'b0);
    add_stamp(32'd1000, ZONE_EAST_LIMIT + 1, 1'b0);
    add_stamp(32'd1000, -64, 1'b0);
    add_stamp(32'd1000, 63, 1'b0);
    // leap day 2000, non-leap century 2100, year rollover
    add_stamp(32'd951782400, 0, 1'b0);
    add_stamp(32'd4107542399, 0, 1'b0);
    add_stamp(32'd4107542400, 0, 1'b0);
    add_stamp(32'd946684799, 1, 1'b0);
    // quarter-hour offsets
    add_stamp(32'd1234567890, -18, 1'b0);
    add_stamp(32'd1234567890, 23, 1'b0);
    add_stamp(32'd1234567890, -33, 1'b0);
    add_stamp(32'd2147483647, ZONE_EAST_LIMIT, 1'b0);

    repeat (RANDOM_STAMPS) begin
      r = $urandom_range(0, 99);
      if (r < 10) secs = $urandom_range(0, 60000);
      else if (r < 15) secs = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
      else secs = $urandom;
      r = $urandom_range(0, 99);
      if (r < 75) zone = int'($urandom_range(0, 104)) + ZONE_WEST_LIMIT;
      else if (r < 80) zone = int'($urandom_range(0, 15)) - 64;
      else if (r < 85) zone = int'($urandom_range(57, 63));
      else if (r < 92) zone = ZONE_WEST_LIMIT;
      else zone = ZONE_EAST_LIMIT;
      add_stamp(secs, zone, $urandom_range(0, 6) == 0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (stamps_sent != stamps_total) @(posedge clk);
    while (expected_civil.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
